>>> design/rfr_pkg.sv
// Types and constants for the reader frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rfr_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd1000;

  // input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_LCS   = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd3;
  localparam logic [2:0] ST_BAD_DCS   = 3'd4;
  localparam logic [2:0] ST_BAD_POST  = 3'd5;
  localparam logic [2:0] ST_TIMEOUT   = 3'd6;

  localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
  localparam logic [7:0] START_LAST     = 8'hFF;
  localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] payload_length;
    logic       last;
  } result_t;

endpackage

>>> design/rfr_in_stage.sv
// Input register for the reader frame receiver: holds one accepted beat.
// Depends on rfr_pkg.
`timescale 1ns / 1ps

module rfr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  rfr_pkg::item_t s_item,
  input  logic           take,
  output logic           item_valid,
  output rfr_pkg::item_t item
);
  import rfr_pkg::*;

  logic full;

  assign s_ready    = !full || take;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_ready) begin
      full <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

>>> design/rfr_step.sv
// Frame parser state and per-beat decode logic.
// Depends on rfr_pkg; one item is processed in the cycle that fire is high.
`timescale 1ns / 1ps

module rfr_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  rfr_pkg::item_t                   item,
  input  logic [rfr_pkg::TimeoutW-1:0]     timeout_ticks,
  output logic                             res_valid,
  output rfr_pkg::result_t                 res
);
  import rfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_LEN, PH_LCS, PH_BODY, PH_DCS, PH_POST
  } phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        header_count, header_count_next;
  logic [7:0]        frame_length, frame_length_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [TimeoutW-1:0] elapsed_ticks, elapsed_ticks_next;

  logic [7:0] b;
  logic [7:0] expected;
  logic [7:0] bytes_left_dec;

  assign b              = item.byte_value;
  assign expected       = (header_count == 2'd2) ? START_LAST : PREAMBLE_BYTE;
  assign bytes_left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    frame_length_next  = frame_length;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    elapsed_ticks_next = elapsed_ticks;
    res_valid          = 1'b0;
    res                = '0;

    if (item.opcode == OP_START) begin
      phase_next         = PH_START;
      header_count_next  = '0;
      frame_length_next  = '0;
      bytes_left_next    = '0;
      running_sum_next   = '0;
      elapsed_ticks_next = '0;
    end else if (item.opcode == OP_TICK && phase != PH_IDLE) begin
      if (elapsed_ticks != '1) begin
        elapsed_ticks_next = elapsed_ticks + 1'b1;
      end
      if (elapsed_ticks_next >= timeout_ticks) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_STATUS;
        res.status      = ST_TIMEOUT;
        res.last        = 1'b1;
        phase_next      = PH_IDLE;
      end
    end else if (item.opcode == OP_BYTE && phase != PH_IDLE) begin
      case (phase)
        PH_START: begin
          if (b != expected) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_START;
          end else if (header_count == 2'd2) begin
            header_count_next = '0;
            phase_next        = PH_LEN;
          end else begin
            header_count_next = header_count + 2'd1;
          end
        end
        PH_LEN: begin
          frame_length_next = b;
          phase_next        = PH_LCS;
        end
        PH_LCS: begin
          if (frame_length + b != 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_LCS;
          end else if (frame_length == 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_ZERO_LEN;
          end else begin
            bytes_left_next  = frame_length;
            running_sum_next = '0;
            phase_next       = PH_BODY;
          end
        end
        PH_BODY: begin
          running_sum_next = running_sum + b;
          bytes_left_next  = bytes_left_dec;
          if (bytes_left_dec == 8'd0) begin
            phase_next = PH_DCS;
          end
          // first body byte is the direction byte, summed but not sent
          if (bytes_left != frame_length) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = b;
          end
        end
        PH_DCS: begin
          if (running_sum + b != 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_DCS;
          end else begin
            phase_next = PH_POST;
          end
        end
        PH_POST: begin
          res_valid = 1'b1;
          if (b != POSTAMBLE_BYTE) begin
            res.status = ST_BAD_POST;
          end else begin
            res.status         = ST_OK;
            res.payload_length = frame_length - 8'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (res_valid && phase != PH_BODY) begin
        res.result_kind = KIND_STATUS;
        res.last        = 1'b1;
        phase_next      = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      frame_length  <= '0;
      bytes_left    <= '0;
      running_sum   <= '0;
      elapsed_ticks <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      frame_length  <= frame_length_next;
      bytes_left    <= bytes_left_next;
      running_sum   <= running_sum_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

>>> design/rfr_out_stage.sv
// Result register for the reader frame receiver, drives the master stream.
// Depends on rfr_pkg.
`timescale 1ns / 1ps

module rfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rfr_pkg::result_t res,
  output logic             free,
  output logic             m_valid,
  input  logic             m_ready,
  output rfr_pkg::result_t m_res
);
  import rfr_pkg::*;

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

>>> design/reader_frame_receiver_unit.sv
// Top level of the reader frame receiver: input register, parser, result register.
// Depends on rfr_pkg, rfr_in_stage, rfr_step, rfr_out_stage.
//
//   channel   dir  beat contents
//   s_axis    in   tuser: opcode; tdata: byte_value
//   m_axis    out  tuser: result_kind; tlast: last; tdata: byte/status/length
//   cfg       in   timeout_ticks write, applies at once
//
// One beat per cycle unless m_axis stalls; the result of an accepted beat (if any) is
// computed by the parser from the input register and loaded into the result register,
// which offers it on m_axis. The parser updates its state on each fired beat.
// rst is synchronous; it clears the parser to idle and the timeout to 1000 ticks.
// A stall on m_axis holds the result register and one beat in the input register.
`timescale 1ns / 1ps

module reader_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                      // [18:11] payload_length, [23:19] zero
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import rfr_pkg::*;

  logic [TimeoutW-1:0] timeout_ticks;
  item_t   s_item, item;
  logic    item_valid, fire, free, res_valid;
  result_t res, m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  assign s_item.opcode     = s_axis_tuser;
  assign s_item.byte_value = s_axis_tdata;
  assign fire              = item_valid && free;

  rfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  rfr_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  rfr_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (fire && res_valid),
    .res     (res),
    .free    (free),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  assign m_axis_tdata = {5'd0, m_res.payload_length, m_res.status, m_res.payload_byte};
  assign m_axis_tuser = m_res.result_kind;
  assign m_axis_tlast = m_res.last;

endmodule

>>> verif/tb_reader_frame_receiver_unit.sv
// Testbench for reader_frame_receiver_unit: a directed table of frames, then random
// well-formed, damaged and cut-short frames, results checked against table or local parser.
// Depends on rfr_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_reader_frame_receiver_unit;
  import rfr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 40;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    RX_IDLE, RX_START, RX_LEN, RX_LCS, RX_BODY, RX_DCS, RX_POST
  } rx_phase_t;

  typedef enum int {
    CLEAN, BAD_SYNC, BAD_LEN_CHECK, NO_BODY, BAD_SUM, BAD_TAIL, CUT_SHORT
  } flaw_t;

  typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC} stall_mode_t;

  typedef struct {
    item_t   item;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] payload_byte, [10:8] status, [18:11] payload_length
  logic        m_axis_tuser;   // [0] result_kind
  logic        m_axis_tlast;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // parser model state
  rx_phase_t   rx_phase = RX_IDLE;
  logic [1:0]  hdr_matched = 2'd0;
  logic [7:0]  rx_len = 8'd0;
  logic [7:0]  body_left = 8'd0;
  logic [7:0]  body_sum = 8'd0;
  logic [15:0] tick_count = 16'd0;
  logic [15:0] timeout_limit = TIMEOUT_RESET;

  result_t  awaited_results[$];
  item_t    frame_items[$];
  dir_row_t dir_table[$];
  int       fail_count = 0;
  int       results_seen = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  bit       hold_off_req = 1'b0;

  always #2 clk = ~clk;

  reader_frame_receiver_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  function automatic result_t status_result(input logic [2:0] code, input logic [7:0] count);
    result_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.status = code;
    r.payload_length = count;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t payload_result(input logic [7:0] b);
    result_t r;
    r = '0;
    r.result_kind = KIND_PAYLOAD;
    r.payload_byte = b;
    return r;
  endfunction

  function automatic bit close_frame(input logic [2:0] code, input logic [7:0] count,
                                     output result_t res);
    res = status_result(code, count);
    rx_phase = RX_IDLE;
    return 1'b1;
  endfunction

  // Advances the parser model by one beat; returns 1 when the beat yields a result.
  function automatic bit parse_item(input item_t it, output result_t res);
    logic [7:0] b;
    bit dir_byte;
    b = it.byte_value;
    res = '0;
    if (it.opcode == OP_START) begin
      rx_phase = RX_START;
      hdr_matched = 2'd0;
      rx_len = 8'd0;
      body_left = 8'd0;
      body_sum = 8'd0;
      tick_count = 16'd0;
      return 1'b0;
    end
    if (it.opcode == OP_UNUSED || rx_phase == RX_IDLE) return 1'b0;
    if (it.opcode == OP_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count >= timeout_limit) return close_frame(ST_TIMEOUT, 8'd0, res);
      return 1'b0;
    end
    case (rx_phase)
      RX_START: begin
        if (b != ((hdr_matched == 2'd2) ? START_LAST : PREAMBLE_BYTE))
          return close_frame(ST_BAD_START, 8'd0, res);
        if (hdr_matched == 2'd2) begin
          hdr_matched = 2'd0;
          rx_phase = RX_LEN;
        end else begin
          hdr_matched++;
        end
      end
      RX_LEN: begin
        rx_len = b;
        rx_phase = RX_LCS;
      end
      RX_LCS: begin
        if (8'(rx_len + b) != 8'd0) return close_frame(ST_BAD_LCS, 8'd0, res);
        if (rx_len == 8'd0) return close_frame(ST_ZERO_LEN, 8'd0, res);
        body_left = rx_len;
        body_sum = 8'd0;
        rx_phase = RX_BODY;
      end
      RX_BODY: begin
        // the first body byte is the direction byte: summed, not forwarded
        dir_byte = (body_left == rx_len);
        body_sum = body_sum + b;
        body_left = body_left - 8'd1;
        if (body_left == 8'd0) rx_phase = RX_DCS;
        if (!dir_byte) begin
          res = payload_result(b);
          return 1'b1;
        end
      end
      RX_DCS: begin
        if (8'(body_sum + b) != 8'd0) return close_frame(ST_BAD_DCS, 8'd0, res);
        rx_phase = RX_POST;
      end
      RX_POST: begin
        if (b != POSTAMBLE_BYTE) return close_frame(ST_BAD_POST, 8'd0, res);
        return close_frame(ST_OK, rx_len - 8'd1, res);
      end
      default: rx_phase = RX_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input logic [7:0] b,
                                   input bit typed = 1'b0, input result_t want = '0);
    dir_row_t r;
    r.item = '{op, b};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want)
      note_failure($sformatf("result %0d %s: expected %0h, got %0h",
                             results_seen, name, want, got));
  endfunction

  // Adds a byte beat, now and then preceded by a tick or an unused opcode.
  function automatic void add_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) frame_items.push_back('{OP_TICK, 8'($urandom)});
    if ($urandom_range(0, 39) == 0) frame_items.push_back('{OP_UNUSED, 8'($urandom)});
    frame_items.push_back('{OP_BYTE, b});
  endfunction

  task automatic build_frame(input bit longest);
    flaw_t flaw;
    int pick, cut, i;
    logic [7:0] len, chk, sum, b;
    pick = $urandom_range(0, 14);
    flaw = (longest || pick < 9) ? CLEAN : flaw_t'(pick - 8);
    if (longest) len = 8'hFF;
    else if (flaw == NO_BODY) len = 8'h00;
    else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, 40));
    else len = 8'($urandom_range(1, 8));
    frame_items.delete();
    frame_items.push_back('{OP_START, 8'($urandom)});
    cut = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      b = (i == 2) ? START_LAST : PREAMBLE_BYTE;
      if (flaw == BAD_SYNC && i == cut) begin
        add_byte(b ^ 8'($urandom_range(1, 255)));
        return;
      end
      add_byte(b);
    end
    // a run of ticks pushes the frame toward its timeout
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 60)) frame_items.push_back('{OP_TICK, 8'($urandom)});
    add_byte(len);
    chk = 8'h00 - len;
    if (flaw == BAD_LEN_CHECK) begin
      add_byte(chk ^ 8'($urandom_range(1, 255)));
      return;
    end
    add_byte(chk);
    if (flaw == NO_BODY) return;
    cut = $urandom_range(0, int'(len) - 1);
    sum = 8'h00;
    for (i = 0; i < int'(len); i++) begin
      if (flaw == CUT_SHORT && i == cut) return;
      b = 8'($urandom);
      sum = sum + b;
      add_byte(b);
    end
    chk = 8'h00 - sum;
    if (flaw == BAD_SUM) begin
      add_byte(chk ^ 8'($urandom_range(1, 255)));
      return;
    end
    add_byte(chk);
    add_byte(flaw == BAD_TAIL ? 8'($urandom_range(1, 255)) : POSTAMBLE_BYTE);
  endtask

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  task automatic push_item(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    bit has_result;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.opcode;
    s_axis_tdata <= it.byte_value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has_result = parse_item(it, predicted);
    if (typed) awaited_results.push_back(want);
    else if (has_result) awaited_results.push_back(predicted);
    @(negedge clk);
    burst_left--;
  endtask

  // Stops the sender and waits until the block has nothing left in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    timeout_limit = ticks;
  endtask

  initial begin : stimulus
    logic [15:0] phase_timeout [6];
    int ph, sent;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = OP_BYTE;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'h0000;

    dir_table.push_back(row(OP_TICK, 8'h00));                 // idle: ignored
    dir_table.push_back(row(OP_UNUSED, 8'hFF));
    dir_table.push_back(row(OP_START, 8'h00));
    dir_table.push_back(row(OP_BYTE, 8'h00));
    dir_table.push_back(row(OP_START, 8'hFF));                // restart mid start code
    dir_table.push_back(row(OP_BYTE, 8'hFF, 1'b1, status_result(ST_BAD_START, 8'd0)));
    dir_table.push_back(row(OP_BYTE, 8'hAB));                 // idle after status
    dir_table.push_back(row(OP_START, 8'h00));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, START_LAST));
    dir_table.push_back(row(OP_BYTE, 8'h00));
    dir_table.push_back(row(OP_BYTE, 8'h00, 1'b1, status_result(ST_ZERO_LEN, 8'd0)));
    dir_table.push_back(row(OP_START, 8'h00));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, START_LAST));
    dir_table.push_back(row(OP_BYTE, 8'h02));
    dir_table.push_back(row(OP_BYTE, 8'h01, 1'b1, status_result(ST_BAD_LCS, 8'd0)));
    dir_table.push_back(row(OP_START, 8'h00));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, START_LAST));
    dir_table.push_back(row(OP_BYTE, 8'h03));
    dir_table.push_back(row(OP_BYTE, 8'hFD));
    dir_table.push_back(row(OP_BYTE, 8'hD5));                 // direction byte
    dir_table.push_back(row(OP_UNUSED, 8'h5A));
    dir_table.push_back(row(OP_TICK, 8'h00));
    dir_table.push_back(row(OP_BYTE, 8'h00, 1'b1, payload_result(8'h00)));
    dir_table.push_back(row(OP_BYTE, 8'hFF, 1'b1, payload_result(8'hFF)));
    dir_table.push_back(row(OP_BYTE, 8'h2C));
    dir_table.push_back(row(OP_BYTE, POSTAMBLE_BYTE, 1'b1, status_result(ST_OK, 8'd2)));
    dir_table.push_back(row(OP_START, 8'h00));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, PREAMBLE_BYTE));
    dir_table.push_back(row(OP_BYTE, START_LAST));
    dir_table.push_back(row(OP_BYTE, 8'h01));
    dir_table.push_back(row(OP_BYTE, 8'hFF));
    dir_table.push_back(row(OP_BYTE, 8'h80));
    dir_table.push_back(row(OP_BYTE, 8'h00, 1'b1, status_result(ST_BAD_DCS, 8'd0)));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) push_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

    // phases may end mid-frame, so some writes land while a frame is open
    phase_timeout = '{16'hFFFF, 16'd1, 16'd3, 16'($urandom_range(4, 40)), 16'd200,
                      TIMEOUT_RESET};
    for (ph = 0; ph < 6; ph++) begin
      settle();
      write_timeout(phase_timeout[ph]);
      if (ph == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_frame(ph == 0 && sent == 0);
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 5)) frame_items.push_back('{2'($urandom), 8'($urandom)});
        foreach (frame_items[k]) begin
          push_item(frame_items[k], 1'b0, '0);
          if (frame_items[k].opcode != OP_UNUSED) sent++;
        end
      end
    end
    settle();

    if (fail_count == 0) $display("[reader_frame_receiver_unit] OK");
    else $display("[reader_frame_receiver_unit] ERROR");
    $finish;
  end

  initial begin : receiver
    stall_mode_t mode;
    int span, period, cnt;
    m_axis_tready = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      period = $urandom_range(2, 5);
      for (cnt = 0; cnt < span; cnt++) begin
        @(negedge clk);
        if (hold_off_req) begin
          // long back-pressure: the sender keeps offering until the input stalls
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            ALWAYS_READY:   m_axis_tready <= 1'b1;
            COIN_FLIP:      m_axis_tready <= 1'($urandom_range(0, 1));
            MOSTLY_STALLED: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:        m_axis_tready <= (cnt % period == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("result %0d not expected: tuser %0b tdata %06h tlast %0b",
                               results_seen, m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", 8'(want.result_kind), 8'(m_axis_tuser));
        check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
        check_field("status", 8'(want.status), 8'(m_axis_tdata[10:8]));
        check_field("payload_length", want.payload_length, m_axis_tdata[18:11]);
        check_field("last", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat accepted for %0d cycles", quiet_cycles);
      $display("[reader_frame_receiver_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> reader_frame_receiver_unit.f
design/rfr_pkg.sv
design/rfr_in_stage.sv
design/rfr_step.sv
design/rfr_out_stage.sv
design/reader_frame_receiver_unit.sv
verif/tb_reader_frame_receiver_unit.sv
